@@ hdl/suffix_max_leader_filter_assert.svh @@
// Assertion macros shared by the leader filter modules.
`ifndef SUFFIX_MAX_LEADER_FILTER_ASSERT_SVH
`define SUFFIX_MAX_LEADER_FILTER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SML_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define SML_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/sml_pkg.sv @@
// ---------------------------------------------------------------------------
// sml_pkg
// Shared widths, defaults and the result beat type of the leader filter.
// ---------------------------------------------------------------------------
package sml_pkg;

   localparam int DEF_MAX_ITEMS = 64;
   localparam int VALUE_W       = 31;

   typedef struct packed {
      logic [VALUE_W-1:0] kept_value;
      logic               last_of_run;
      logic               overflowed;
   } beat_type;

endpackage

@@ hdl/sml_store.sv @@
// ---------------------------------------------------------------------------
// sml_store
// Stack storage: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module sml_store
   import sml_pkg::*;
#(
   parameter int MAX_ITEMS = DEF_MAX_ITEMS,
   parameter int AW        = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [AW-1:0]      wr_addr,
   input  logic [VALUE_W-1:0] wr_data,
   input  logic               rd_en,
   input  logic [AW-1:0]      rd_addr,
   output logic [VALUE_W-1:0] rd_data
);

   logic [VALUE_W-1:0] mem_ff [MAX_ITEMS];
   logic [VALUE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/sml_out.sv @@
// ---------------------------------------------------------------------------
// sml_out
// Result register: holds one beat until the receiver takes it.
// ---------------------------------------------------------------------------
module sml_out
   import sml_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  beat_type           beat,
   output logic               free,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [VALUE_W-1:0] rsp_kept_value,
   output logic               rsp_last_of_run,
   output logic               rsp_overflowed
);

`include "suffix_max_leader_filter_assert.svh"

   logic     valid_ff;
   logic     valid_in;
   beat_type beat_ff;

   assign free = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff && rsp_stall;
      if (load) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         beat_ff <= beat;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_kept_value  = beat_ff.kept_value;
   assign rsp_last_of_run = beat_ff.last_of_run;
   assign rsp_overflowed  = beat_ff.overflowed;

   // a held beat must never be overwritten
   `SML_ASSERT_NOW(a_load_when_free, load, free, "result register overwritten")
   `SML_ASSERT_NEXT(a_load_shows, load, valid_ff, "loaded beat not presented")

endmodule

@@ hdl/suffix_max_leader_filter.sv @@
// ---------------------------------------------------------------------------
// suffix_max_leader_filter
// Keeps each value not exceeded by any later value, emits them on the last beat.
// ---------------------------------------------------------------------------
// Values are held as a monotonic stack in a single-port-read memory with
// registered read data. An input beat on an empty stack is pushed straight
// away; otherwise the top entry is read and compared, each stored value
// smaller than the new one is removed in turn, and the new value is then
// pushed. Each value is removed at most once. On the marked final beat the
// survivors are read back oldest first, each result beat waiting while the
// receiver stalls; no input is taken during that read-back. The result
// register lets a finished beat wait while the next sequence starts. Values
// that still find the stack full after removals are dropped and every result
// beat of that sequence carries the overflow flag.
module suffix_max_leader_filter
   import sml_pkg::*;
#(
   parameter int MAX_ITEMS = DEF_MAX_ITEMS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [VALUE_W-1:0] req_item_value,
   input  logic               req_last_item,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [VALUE_W-1:0] rsp_kept_value,
   output logic               rsp_last_of_run,
   output logic               rsp_overflowed
);

`include "suffix_max_leader_filter_assert.svh"

   localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int CW = $clog2(MAX_ITEMS + 1);
   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ITEMS);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_RD   = 3'd1;
   localparam logic [2:0] S_CMP  = 3'd2;
   localparam logic [2:0] S_ER   = 3'd3;
   localparam logic [2:0] S_EW   = 3'd4;

   logic [2:0]         state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic               ovf_ff, ovf_in;
   logic [AW-1:0]      idx_ff, idx_in;
   logic [VALUE_W-1:0] val_ff;
   logic               last_ff;

   logic               wr_en, rd_en;
   logic [AW-1:0]      wr_addr, rd_addr;
   logic [VALUE_W-1:0] rd_data;
   logic               out_load, out_free;
   beat_type           out_beat;
   logic               req_take, last_hit, do_push;
   logic [CW-1:0]      count_dec;

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign count_dec = count_ff - CW'(1);
   assign last_hit  = ((CW'(idx_ff) + CW'(1)) == count_ff);

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      ovf_in   = ovf_ff;
      idx_in   = idx_ff;
      wr_en    = 1'b0;
      wr_addr  = count_ff[AW-1:0];
      rd_en    = 1'b0;
      rd_addr  = count_dec[AW-1:0];
      out_load = 1'b0;
      do_push  = 1'b0;
      out_beat.kept_value  = rd_data;
      out_beat.last_of_run = last_hit;
      out_beat.overflowed  = ovf_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               state_in = S_RD;
            end
         end
         S_RD: begin
            if (count_ff == '0) begin
               do_push = 1'b1;
            end else begin
               rd_en    = 1'b1;
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            // top entry strictly smaller than the new value is popped
            if (rd_data < val_ff) begin
               count_in = count_dec;
               state_in = S_RD;
            end else begin
               do_push = 1'b1;
            end
         end
         S_ER: begin
            rd_en    = 1'b1;
            rd_addr  = idx_ff;
            state_in = S_EW;
         end
         S_EW: begin
            if (out_free) begin
               out_load = 1'b1;
               if (last_hit) begin
                  count_in = '0;
                  ovf_in   = 1'b0;
                  state_in = S_IDLE;
               end else begin
                  idx_in   = idx_ff + AW'(1);
                  state_in = S_ER;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (do_push) begin
         if (count_ff < MAX_CNT) begin
            wr_en    = 1'b1;
            count_in = count_ff + CW'(1);
         end else begin
            ovf_in = 1'b1;
         end
         idx_in   = '0;
         state_in = last_ff ? S_ER : S_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         idx_ff   <= idx_in;
      end
      if (req_take) begin
         val_ff  <= req_item_value;
         last_ff <= req_last_item;
      end
   end

   sml_store #(
      .MAX_ITEMS (MAX_ITEMS),
      .AW        (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (val_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   sml_out u_out (
      .clock           (clock),
      .reset           (reset),
      .load            (out_load),
      .beat            (out_beat),
      .free            (out_free),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kept_value  (rsp_kept_value),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_overflowed  (rsp_overflowed)
   );

   `SML_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= MAX_CNT, "stack count past capacity")
   `SML_ASSERT_NOW(a_emit_nonempty, state_ff == S_EW, count_ff != '0, "read-back of empty stack")
   `SML_ASSERT_NEXT(a_run_clears, out_load && last_hit,
      count_ff == '0 && !ovf_ff, "state not cleared after final beat")
   `SML_ASSERT_NEXT(a_take_starts, req_take, state_ff == S_RD, "accepted beat not processed")

endmodule

@@ tb/sv/suffix_max_leader_filter_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// suffix_max_leader_filter_tb
// Drives value sequences into the leader filter and checks every result beat
// against a monotonic-stack predictor kept in the bench. Covers directed
// corners, stack capacity and overflow, and random sequences with random
// gaps on the input side and random stalls on the result side.
// ---------------------------------------------------------------------------
module suffix_max_leader_filter_tb;
   import sml_pkg::*;

   localparam int          DEPTH       = DEF_MAX_ITEMS;
   localparam logic [30:0] VMAX        = {VALUE_W{1'b1}};
   localparam int          CYCLE_LIMIT = 400000;
   localparam int          RANDOM_BEATS = 160;
   localparam int          TAIL_CYCLES = 200;
   localparam int          REPORT_MAX  = 10;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [VALUE_W-1:0] req_item_value = '0;
   logic               req_last_item = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [VALUE_W-1:0] rsp_kept_value;
   logic               rsp_last_of_run;
   logic               rsp_overflowed;

   // leader stack mirror
   logic [VALUE_W-1:0] leader_stack [DEPTH];
   int                 leader_depth = 0;
   logic               drop_seen = 1'b0;
   beat_type           pending_beats [$];

   int  mismatches = 0;
   int  cycle_count = 0;
   int  stall_left = 0;
   bit  idle_on = 1'b1;
   int  stall_pct = 25;

   suffix_max_leader_filter u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_item_value  (req_item_value),
      .req_last_item   (req_last_item),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kept_value  (rsp_kept_value),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_overflowed  (rsp_overflowed)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("suffix_max_leader_filter_tb: errors");
         $finish;
      end
   end

   // result-side stalls: mostly short, a few long
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else if (idle_on && $urandom_range(0, 99) < stall_pct) begin
         rsp_stall <= 1'b1;
         if ($urandom_range(0, 9) == 0)
            stall_left <= $urandom_range(10, 40);
         else
            stall_left <= $urandom_range(0, 2);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // pop smaller entries, push or drop, emit survivors on the last value
   function automatic void track_leaders(input logic [VALUE_W-1:0] v, input logic last);
      beat_type b;
      while (leader_depth > 0 && leader_stack[leader_depth-1] < v)
         leader_depth--;
      if (leader_depth < DEPTH) begin
         leader_stack[leader_depth] = v;
         leader_depth++;
      end else begin
         drop_seen = 1'b1;
      end
      if (last) begin
         for (int k = 0; k < leader_depth; k++) begin
            b.kept_value  = leader_stack[k];
            b.last_of_run = (k == leader_depth - 1);
            b.overflowed  = drop_seen;
            pending_beats.push_back(b);
         end
         leader_depth = 0;
         drop_seen    = 1'b0;
      end
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!idle_on || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // one input beat: optional gap, then hold until accepted
   task automatic send_value(input logic [VALUE_W-1:0] v, input logic last);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_item_value <= v;
      req_last_item  <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      track_leaders(v, last);
   endtask

   always @(posedge clock) begin
      beat_type got;
      beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.kept_value  = rsp_kept_value;
         got.last_of_run = rsp_last_of_run;
         got.overflowed  = rsp_overflowed;
         if (pending_beats.size() == 0) begin
            if (mismatches < REPORT_MAX)
               $display("unexpected beat: value=%0h last=%0b ovf=%0b",
                        got.kept_value, got.last_of_run, got.overflowed);
            mismatches++;
         end else begin
            want = pending_beats.pop_front();
            if (got.kept_value !== want.kept_value || got.last_of_run !== want.last_of_run ||
                got.overflowed !== want.overflowed) begin
               if (mismatches < REPORT_MAX)
                  $display("mismatch: exp value=%0h last=%0b ovf=%0b, got value=%0h last=%0b ovf=%0b",
                           want.kept_value, want.last_of_run, want.overflowed,
                           got.kept_value, got.last_of_run, got.overflowed);
               mismatches++;
            end
         end
      end
   end

   task automatic test_directed();
      // single values at both extremes
      send_value('0, 1'b1);
      send_value(VMAX, 1'b1);
      // rising run keeps only the last
      send_value(31'd1, 1'b0);
      send_value(31'd2, 1'b0);
      send_value(31'd3, 1'b1);
      // falling run keeps everything
      send_value(31'd5, 1'b0);
      send_value(31'd4, 1'b0);
      send_value(31'd3, 1'b1);
      // equal values are not removed
      send_value(31'd7, 1'b0);
      send_value(31'd7, 1'b0);
      send_value(31'd7, 1'b1);
      // mixed: 17, 5, 2 survive
      send_value(31'd16, 1'b0);
      send_value(31'd17, 1'b0);
      send_value(31'd4, 1'b0);
      send_value(31'd3, 1'b0);
      send_value(31'd5, 1'b0);
      send_value(31'd2, 1'b1);
      // max then zero; then a value popping a two-entry stack of alternating bits
      send_value(VMAX, 1'b0);
      send_value('0, 1'b1);
      send_value(31'h2AAA_AAAA, 1'b0);
      send_value(31'h1555_5555, 1'b0);
      send_value(VMAX - 31'd1, 1'b1);
   endtask

   // non-increasing run of n values starting near the top of the range, optionally ending in final_value
   task automatic send_falling(input int n, input logic [VALUE_W-1:0] final_value,
                               input bit use_final);
      logic [VALUE_W-1:0] v;
      v = VMAX - VALUE_W'($urandom_range(0, 15));
      for (int i = 0; i < n; i++) begin
         if (i == n - 1 && use_final)
            send_value(final_value, 1'b1);
         else
            send_value(v, i == n - 1);
         v = v - VALUE_W'($urandom_range(0, 3));
      end
   endtask

   task automatic test_capacity();
      // exactly full: no drop
      send_falling(DEPTH, '0, 1'b0);
      // one past full: last value dropped
      send_falling(DEPTH + 1, '0, 1'b0);
      // overflow, then a final max pops every smaller entry
      send_falling(DEPTH + 6, VMAX, 1'b1);
      // overflow followed by a partial pop and refill
      send_falling(DEPTH + 3, VMAX - 31'd40, 1'b1);
   endtask

   function automatic logic [VALUE_W-1:0] pick_value(input int mode);
      case (mode)
         0:       return VALUE_W'($urandom() & VMAX);
         1:       return VALUE_W'($urandom_range(0, 15));
         default: return ($urandom_range(0, 1) != 0) ? VMAX - VALUE_W'($urandom_range(0, 1))
                                                    : VALUE_W'($urandom_range(0, 1));
      endcase
   endfunction

   task automatic test_random();
      int sent;
      int len;
      int mode;
      int r;
      sent = 0;
      while (sent < RANDOM_BEATS) begin
         idle_on   = ($urandom_range(0, 3) != 0);
         stall_pct = $urandom_range(0, 50);
         r = $urandom_range(0, 99);
         if (r < 8) begin
            len = $urandom_range(DEPTH - 2, DEPTH + 10);
            send_falling(len, pick_value($urandom_range(0, 2)), 1'($urandom_range(0, 1)));
         end else begin
            len  = (r < 75) ? $urandom_range(1, 8) : $urandom_range(9, 30);
            mode = $urandom_range(0, 2);
            for (int i = 0; i < len; i++)
               send_value(pick_value(mode), i == len - 1);
         end
         sent += len;
      end
      idle_on = 1'b1;
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_capacity();
      test_random();
      @(posedge clock);
      req_valid <= 1'b0;
      while (pending_beats.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_beats.size() == 0)
         $display("suffix_max_leader_filter_tb: clean");
      else
         $display("suffix_max_leader_filter_tb: errors");
      $finish;
   end

endmodule
